// ===== rtl/core/acct_pkg.sv =====
// ----------------------------------------------------------------------------
// acct_pkg - shared types and constants for the shape pair collision test
// Holds the default coordinate width and the control word that travels with
// each request down the pipeline.
// ----------------------------------------------------------------------------
package acct_pkg;

	localparam int unsigned COORD_WIDTH = 24;

	// Control word of one pipeline stage.
	typedef struct packed {
		logic valid;     // stage holds a request
		logic overlap;   // bounding boxes overlap strictly
		logic box_pair;  // both shapes are boxes: overlap alone decides
	} ctrl_t;

endpackage

// ===== rtl/core/acct_pair_if.sv =====
// ----------------------------------------------------------------------------
// acct_pair_if - request channel carrying one pair of shapes
// Valid/ready handshake; the payload holds type, corner and size of each shape.
// ----------------------------------------------------------------------------
interface acct_pair_if #(
	parameter int unsigned COORD_WIDTH = acct_pkg::COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic                          first_is_circle;
	logic                          second_is_circle;
	logic signed [COORD_WIDTH-1:0] first_left;
	logic signed [COORD_WIDTH-1:0] first_top;
	logic        [COORD_WIDTH-2:0] first_width;
	logic        [COORD_WIDTH-2:0] first_height;
	logic signed [COORD_WIDTH-1:0] second_left;
	logic signed [COORD_WIDTH-1:0] second_top;
	logic        [COORD_WIDTH-2:0] second_width;
	logic        [COORD_WIDTH-2:0] second_height;

	modport source (
		output valid, first_is_circle, second_is_circle,
		output first_left, first_top, first_width, first_height,
		output second_left, second_top, second_width, second_height,
		input  ready
	);

	modport sink (
		input  valid, first_is_circle, second_is_circle,
		input  first_left, first_top, first_width, first_height,
		input  second_left, second_top, second_width, second_height,
		output ready
	);
endinterface

// ===== rtl/core/acct_result_if.sv =====
// ----------------------------------------------------------------------------
// acct_result_if - result channel of the collision test
// Valid/ready handshake; the payload holds the fine hit and the box overlap.
// ----------------------------------------------------------------------------
interface acct_result_if;
	logic valid;
	logic ready;
	logic collides;
	logic boxes_overlap;

	modport source (output valid, collides, boxes_overlap, input ready);
	modport sink   (input valid, collides, boxes_overlap, output ready);
endinterface

// ===== rtl/core/acct_setup.sv =====
// ----------------------------------------------------------------------------
// acct_setup - stage 1: box overlap test and doubled-unit geometry
// Picks the circle, computes its doubled center, the doubled clamp window
// and the doubled radius; registers them with the overlap flag.
// ----------------------------------------------------------------------------
module acct_setup #(
	parameter int unsigned COORD_WIDTH = acct_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic                          first_is_circle,
	input  logic                          second_is_circle,
	input  logic signed [COORD_WIDTH-1:0] first_left,
	input  logic signed [COORD_WIDTH-1:0] first_top,
	input  logic        [COORD_WIDTH-2:0] first_width,
	input  logic        [COORD_WIDTH-2:0] first_height,
	input  logic signed [COORD_WIDTH-1:0] second_left,
	input  logic signed [COORD_WIDTH-1:0] second_top,
	input  logic        [COORD_WIDTH-2:0] second_width,
	input  logic        [COORD_WIDTH-2:0] second_height,
	output acct_pkg::ctrl_t               ctrl_s1,
	output logic signed [COORD_WIDTH+1:0] cx_s1,
	output logic signed [COORD_WIDTH+1:0] cy_s1,
	output logic signed [COORD_WIDTH+1:0] lox_s1,
	output logic signed [COORD_WIDTH+1:0] hix_s1,
	output logic signed [COORD_WIDTH+1:0] loy_s1,
	output logic signed [COORD_WIDTH+1:0] hiy_s1,
	output logic        [COORD_WIDTH-1:0] rad_s1
);
	localparam int unsigned EW = COORD_WIDTH + 2;

	logic signed [EW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
	logic signed [EW-1:0] a_right, a_bottom, b_right, b_bottom;
	logic signed [EW-1:0] a_cx, a_cy, b_cx, b_cy;
	logic                 overlap, both_circle, second_only;
	logic [COORD_WIDTH-1:0] rad_sum;

	always_comb begin
		ax = EW'(first_left);
		ay = EW'(first_top);
		bx = EW'(second_left);
		by = EW'(second_top);
		aw = EW'({3'b000, first_width});
		ah = EW'({3'b000, first_height});
		bw = EW'({3'b000, second_width});
		bh = EW'({3'b000, second_height});

		a_right  = ax + aw;
		a_bottom = ay + ah;
		b_right  = bx + bw;
		b_bottom = by + bh;

		// Touching edges do not count.
		overlap = !((a_right <= bx) || (ax >= b_right) ||
			(a_bottom <= by) || (ay >= b_bottom));

		a_cx = (ax <<< 1) + aw;
		a_cy = (ay <<< 1) + ah;
		b_cx = (bx <<< 1) + bw;
		b_cy = (by <<< 1) + bh;

		both_circle = first_is_circle & second_is_circle;
		second_only = second_is_circle & ~first_is_circle;
		rad_sum     = COORD_WIDTH'({1'b0, first_width}) + COORD_WIDTH'({1'b0, second_width});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1.valid    <= in_valid;
			ctrl_s1.overlap  <= overlap;
			ctrl_s1.box_pair <= ~first_is_circle & ~second_is_circle;
		end
	end

	// Circle against circle uses a degenerate window at the other center.
	always_ff @(posedge clk) begin
		if (en) begin
			if (second_only) begin
				cx_s1  <= b_cx;
				cy_s1  <= b_cy;
				lox_s1 <= ax <<< 1;
				hix_s1 <= a_right <<< 1;
				loy_s1 <= ay <<< 1;
				hiy_s1 <= a_bottom <<< 1;
				rad_s1 <= COORD_WIDTH'({1'b0, second_width});
			end else if (both_circle) begin
				cx_s1  <= a_cx;
				cy_s1  <= a_cy;
				lox_s1 <= b_cx;
				hix_s1 <= b_cx;
				loy_s1 <= b_cy;
				hiy_s1 <= b_cy;
				rad_s1 <= rad_sum;
			end else begin
				cx_s1  <= a_cx;
				cy_s1  <= a_cy;
				lox_s1 <= bx <<< 1;
				hix_s1 <= b_right <<< 1;
				loy_s1 <= by <<< 1;
				hiy_s1 <= b_bottom <<< 1;
				rad_s1 <= COORD_WIDTH'({1'b0, first_width});
			end
		end
	end
endmodule

// ===== rtl/core/acct_offset.sv =====
// ----------------------------------------------------------------------------
// acct_offset - stage 2: distance from circle center to its clamp point
// Clamps the center into the window and takes the absolute offset per axis.
// ----------------------------------------------------------------------------
module acct_offset #(
	parameter int unsigned COORD_WIDTH = acct_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  acct_pkg::ctrl_t               ctrl_s1,
	input  logic signed [COORD_WIDTH+1:0] cx_s1,
	input  logic signed [COORD_WIDTH+1:0] cy_s1,
	input  logic signed [COORD_WIDTH+1:0] lox_s1,
	input  logic signed [COORD_WIDTH+1:0] hix_s1,
	input  logic signed [COORD_WIDTH+1:0] loy_s1,
	input  logic signed [COORD_WIDTH+1:0] hiy_s1,
	input  logic        [COORD_WIDTH-1:0] rad_s1,
	output acct_pkg::ctrl_t               ctrl_s2,
	output logic        [COORD_WIDTH-1:0] dx_s2,
	output logic        [COORD_WIDTH-1:0] dy_s2,
	output logic        [COORD_WIDTH-1:0] rad_s2
);
	localparam int unsigned EW = COORD_WIDTH + 2;

	logic [EW-1:0] dx_full, dy_full;

	// While the boxes overlap the offset stays below 2^COORD_WIDTH, so the
	// low bits are exact; otherwise the result is masked later anyway.
	always_comb begin
		if (cx_s1 < lox_s1) begin
			dx_full = EW'(lox_s1 - cx_s1);
		end else if (cx_s1 > hix_s1) begin
			dx_full = EW'(cx_s1 - hix_s1);
		end else begin
			dx_full = '0;
		end
		if (cy_s1 < loy_s1) begin
			dy_full = EW'(loy_s1 - cy_s1);
		end else if (cy_s1 > hiy_s1) begin
			dy_full = EW'(cy_s1 - hiy_s1);
		end else begin
			dy_full = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2  <= dx_full[COORD_WIDTH-1:0];
			dy_s2  <= dy_full[COORD_WIDTH-1:0];
			rad_s2 <= rad_s1;
		end
	end
endmodule

// ===== rtl/core/acct_square.sv =====
// ----------------------------------------------------------------------------
// acct_square - stage 3: squares of both offsets and of the radius
// Three parallel multipliers, each registered.
// ----------------------------------------------------------------------------
module acct_square #(
	parameter int unsigned COORD_WIDTH = acct_pkg::COORD_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  acct_pkg::ctrl_t                 ctrl_s2,
	input  logic [COORD_WIDTH-1:0]          dx_s2,
	input  logic [COORD_WIDTH-1:0]          dy_s2,
	input  logic [COORD_WIDTH-1:0]          rad_s2,
	output acct_pkg::ctrl_t                 ctrl_s3,
	output logic [2*COORD_WIDTH-1:0]        dx2_s3,
	output logic [2*COORD_WIDTH-1:0]        dy2_s3,
	output logic [2*COORD_WIDTH-1:0]        rad2_s3
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s3  <= (2*COORD_WIDTH)'(dx_s2) * (2*COORD_WIDTH)'(dx_s2);
			dy2_s3  <= (2*COORD_WIDTH)'(dy_s2) * (2*COORD_WIDTH)'(dy_s2);
			rad2_s3 <= (2*COORD_WIDTH)'(rad_s2) * (2*COORD_WIDTH)'(rad_s2);
		end
	end
endmodule

// ===== rtl/core/aabb_circle_collision_test_top.sv =====
// ----------------------------------------------------------------------------
// aabb_circle_collision_test_top - streaming collision test for shape pairs
// Strict bounding box overlap plus exact circle/box fine test per request.
// ----------------------------------------------------------------------------
// Usage:
//   pair   : request channel (valid/ready). Each request is two shapes, each
//            a box or a circle, given by signed corner and unsigned size in
//            fixed point with 8 fraction bits.
//   result : response channel (valid/ready) with collides and boxes_overlap,
//            one response per request, in request order.
// Throughput: one request per cycle while no response sits unaccepted in the
//   output register (see Stall); no state links requests. A request passes
//   through four register stages in order: setup (box test, doubled centers
//   and clamp window), offset (clamp and absolute distance), square (three
//   multipliers) and the output register (sum of squares against squared
//   radius), which drives result.valid.
// Stall: the whole pipeline holds while a response sits unaccepted in the
//   output register; pair.ready is low exactly then. An empty output register
//   never holds the pipeline, so nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits at once; the block is ready to
//   accept a request as soon as reset is released.
// ----------------------------------------------------------------------------
module aabb_circle_collision_test_top #(
	parameter int unsigned COORD_WIDTH = acct_pkg::COORD_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	acct_pair_if.sink   pair,
	acct_result_if.source result
);
	logic                            en;
	acct_pkg::ctrl_t                 ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [COORD_WIDTH+1:0]   cx_s1, cy_s1, lox_s1, hix_s1, loy_s1, hiy_s1;
	logic [COORD_WIDTH-1:0]          rad_s1, dx_s2, dy_s2, rad_s2;
	logic [2*COORD_WIDTH-1:0]        dx2_s3, dy2_s3, rad2_s3;
	logic [2*COORD_WIDTH:0]          dist2;
	logic                            in_reach;
	logic                            valid_s4, collides_s4, overlap_s4;

	// Advance every stage together unless the output holds an untaken response.
	assign en         = ~valid_s4 | result.ready;
	assign pair.ready = en;

	acct_setup #(.COORD_WIDTH(COORD_WIDTH)) u_setup (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_valid         (pair.valid),
		.first_is_circle  (pair.first_is_circle),
		.second_is_circle (pair.second_is_circle),
		.first_left       (pair.first_left),
		.first_top        (pair.first_top),
		.first_width      (pair.first_width),
		.first_height     (pair.first_height),
		.second_left      (pair.second_left),
		.second_top       (pair.second_top),
		.second_width     (pair.second_width),
		.second_height    (pair.second_height),
		.ctrl_s1          (ctrl_s1),
		.cx_s1            (cx_s1),
		.cy_s1            (cy_s1),
		.lox_s1           (lox_s1),
		.hix_s1           (hix_s1),
		.loy_s1           (loy_s1),
		.hiy_s1           (hiy_s1),
		.rad_s1           (rad_s1)
	);

	acct_offset #(.COORD_WIDTH(COORD_WIDTH)) u_offset (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctrl_s1 (ctrl_s1),
		.cx_s1   (cx_s1),
		.cy_s1   (cy_s1),
		.lox_s1  (lox_s1),
		.hix_s1  (hix_s1),
		.loy_s1  (loy_s1),
		.hiy_s1  (hiy_s1),
		.rad_s1  (rad_s1),
		.ctrl_s2 (ctrl_s2),
		.dx_s2   (dx_s2),
		.dy_s2   (dy_s2),
		.rad_s2  (rad_s2)
	);

	acct_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctrl_s2 (ctrl_s2),
		.dx_s2   (dx_s2),
		.dy_s2   (dy_s2),
		.rad_s2  (rad_s2),
		.ctrl_s3 (ctrl_s3),
		.dx2_s3  (dx2_s3),
		.dy2_s3  (dy2_s3),
		.rad2_s3 (rad2_s3)
	);

	// Sum carries one extra bit so a large distance never wraps into a hit.
	assign dist2    = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	assign in_reach = dist2 < {1'b0, rad2_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= ctrl_s3.valid;
		end
	end

	// A box pair hits on overlap alone; any circle also needs the fine test.
	always_ff @(posedge clk) begin
		if (en) begin
			overlap_s4  <= ctrl_s3.overlap;
			collides_s4 <= ctrl_s3.overlap & (ctrl_s3.box_pair | in_reach);
		end
	end

	assign result.valid         = valid_s4;
	assign result.collides      = collides_s4;
	assign result.boxes_overlap = overlap_s4;
endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the shape pair collision test
// Streams shape pair requests into the block, predicts the box overlap and
// fine hit of every accepted request, and checks each response in order.
// Covers directed edge and extreme cases, a long response stall, a drain
// pause, random near and far pairs, and a back-to-back stream at the end.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CW          = acct_pkg::COORD_WIDTH;
	localparam int CYCLE_LIMIT = 500000;
	// Pipeline depth from the block header, plus a few spare cycles.
	localparam int DRAIN_CYCLES = 8;

	typedef longint unsigned u64_t;

	// One request: two shapes, each a box or a circle.
	typedef struct {
		logic                 first_is_circle;
		logic                 second_is_circle;
		logic signed [CW-1:0] first_left;
		logic signed [CW-1:0] first_top;
		logic        [CW-2:0] first_width;
		logic        [CW-2:0] first_height;
		logic signed [CW-1:0] second_left;
		logic signed [CW-1:0] second_top;
		logic        [CW-2:0] second_width;
		logic        [CW-2:0] second_height;
	} shape_pair_t;

	// One response as the block reports it.
	typedef struct {
		logic collides;
		logic boxes_overlap;
	} verdict_t;

	logic clk;
	logic arst_n;

	acct_pair_if #(.COORD_WIDTH(CW)) pair_ch();
	acct_result_if                   result_ch();

	aabb_circle_collision_test_top #(.COORD_WIDTH(CW)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.result (result_ch)
	);

	// Verdicts of accepted requests, oldest first.
	verdict_t pending_verdicts[$];
	int       error_count;
	int       cycle_count;
	// Random idling on both channels; cleared for the final stretch.
	bit       idling_enabled;
	// Cycles the response side must still hold off; counted by the receiver.
	int       hold_off_left;

	// ------------------------------------------------------------------------
	// Prediction, in doubled units so centers and radii stay integral
	// ------------------------------------------------------------------------
	function automatic u64_t span_between(longint a, longint b);
		return (a >= b) ? u64_t'(a - b) : u64_t'(b - a);
	endfunction

	// Exact dx^2 + dy^2 < radius^2; an overflowing sum is never a hit.
	function automatic bit nearer_than(u64_t dx, u64_t dy, u64_t radius);
		u64_t dx_sq;
		u64_t dist_sq;
		dx_sq   = dx * dx;
		dist_sq = dx_sq + dy * dy;
		if (dist_sq < dx_sq)
			return 1'b0;
		return dist_sq < radius * radius;
	endfunction

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Circle center against the nearest point of the box.
	function automatic bit circle_hits_box(longint cx, longint cy, longint cw, longint ch,
	                                       longint bx, longint by, longint bw, longint bh);
		longint ccx;
		longint ccy;
		longint px;
		longint py;
		ccx = 2 * cx + cw;
		ccy = 2 * cy + ch;
		px  = clamp_to(ccx, 2 * bx, 2 * (bx + bw));
		py  = clamp_to(ccy, 2 * by, 2 * (by + bh));
		return nearer_than(span_between(px, ccx), span_between(py, ccy), u64_t'(cw));
	endfunction

	function automatic verdict_t predict_verdict(shape_pair_t p);
		longint   ax, ay, aw, ah;
		longint   bx, by, bw, bh;
		verdict_t v;
		ax = longint'(p.first_left);
		ay = longint'(p.first_top);
		aw = longint'(p.first_width);
		ah = longint'(p.first_height);
		bx = longint'(p.second_left);
		by = longint'(p.second_top);
		bw = longint'(p.second_width);
		bh = longint'(p.second_height);
		// Strict test: shared edges do not overlap.
		v.boxes_overlap = !(ax + aw <= bx || ax >= bx + bw ||
		                    ay + ah <= by || ay >= by + bh);
		if (!v.boxes_overlap)
			v.collides = 1'b0;
		else if (!p.first_is_circle && !p.second_is_circle)
			v.collides = 1'b1;
		else if (p.first_is_circle && p.second_is_circle)
			v.collides = nearer_than(span_between(2 * ax + aw, 2 * bx + bw),
			                         span_between(2 * ay + ah, 2 * by + bh),
			                         u64_t'(aw + bw));
		else if (p.second_is_circle)
			v.collides = circle_hits_box(bx, by, bw, bh, ax, ay, aw, ah);
		else
			v.collides = circle_hits_box(ax, ay, aw, ah, bx, by, bw, bh);
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic shape_pair_t make_pair(bit fc, bit sc,
	                                          longint fl, longint ft, longint fw, longint fh,
	                                          longint sl, longint st, longint sw, longint sh);
		shape_pair_t p;
		p.first_is_circle  = fc;
		p.second_is_circle = sc;
		p.first_left       = fl[CW-1:0];
		p.first_top        = ft[CW-1:0];
		p.first_width      = fw[CW-2:0];
		p.first_height     = fh[CW-2:0];
		p.second_left      = sl[CW-1:0];
		p.second_top       = st[CW-1:0];
		p.second_width     = sw[CW-2:0];
		p.second_height    = sh[CW-2:0];
		return p;
	endfunction

	// Mostly small sizes, sometimes large, now and then zero or full width.
	function automatic logic [CW-2:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return (CW-1)'($urandom);
		if (sel == 1)
			return '0;
		if (sel < 5)
			return (CW-1)'($urandom_range(0, 1 << 20));
		return (CW-1)'($urandom_range(0, 4095));
	endfunction

	// Second shape placed around the first so boxes overlap often and the
	// fine test decides near the edges.
	function automatic shape_pair_t random_near_pair();
		shape_pair_t p;
		longint      pos;
		p.first_is_circle  = 1'($urandom);
		p.second_is_circle = 1'($urandom);
		p.first_left       = CW'($urandom);
		p.first_top        = CW'($urandom);
		p.first_width      = pick_size();
		p.first_height     = (p.first_is_circle && $urandom_range(0, 1)) ?
		                     p.first_width : pick_size();
		p.second_width     = pick_size();
		p.second_height    = (p.second_is_circle && $urandom_range(0, 1)) ?
		                     p.second_width : pick_size();
		pos = longint'(p.first_left) - longint'(p.second_width) - 1 +
		      longint'($urandom_range(0, p.first_width + p.second_width + 2));
		p.second_left = pos[CW-1:0];
		pos = longint'(p.first_top) - longint'(p.second_height) - 1 +
		      longint'($urandom_range(0, p.first_height + p.second_height + 2));
		p.second_top = pos[CW-1:0];
		return p;
	endfunction

	function automatic shape_pair_t random_any_pair();
		shape_pair_t p;
		p.first_is_circle  = 1'($urandom);
		p.second_is_circle = 1'($urandom);
		p.first_left       = CW'($urandom);
		p.first_top        = CW'($urandom);
		p.first_width      = (CW-1)'($urandom);
		p.first_height     = (CW-1)'($urandom);
		p.second_left      = CW'($urandom);
		p.second_top       = CW'($urandom);
		p.second_width     = (CW-1)'($urandom);
		p.second_height    = (CW-1)'($urandom);
		return p;
	endfunction

	task automatic load_payload(shape_pair_t p);
		pair_ch.first_is_circle  <= p.first_is_circle;
		pair_ch.second_is_circle <= p.second_is_circle;
		pair_ch.first_left       <= p.first_left;
		pair_ch.first_top        <= p.first_top;
		pair_ch.first_width      <= p.first_width;
		pair_ch.first_height     <= p.first_height;
		pair_ch.second_left      <= p.second_left;
		pair_ch.second_top       <= p.second_top;
		pair_ch.second_width     <= p.second_width;
		pair_ch.second_height    <= p.second_height;
	endtask

	// Offer one request and hold it until accepted; then record its verdict.
	// Called right after a rising edge.
	task automatic send_pair(shape_pair_t p);
		if (idling_enabled && $urandom_range(0, 7) == 0) begin
			// Drop valid for a random burst before this request.
			pair_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pair_ch.valid <= 1'b1;
		load_payload(p);
		@(posedge clk);
		while (!pair_ch.ready)
			@(posedge clk);
		pending_verdicts.push_back(predict_verdict(p));
	endtask

	// Stop offering and wait for every outstanding response.
	task automatic wait_drained();
		pair_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	localparam longint CMIN = -(longint'(1) << (CW - 1));
	localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint SMAX = (longint'(1) << (CW - 1)) - 1;

	task automatic test_box_pairs();
		// Plain overlap.
		send_pair(make_pair(0, 0, 0, 0, 1024, 1024, 512, 512, 1024, 1024));
		// Shared right edge, then shared bottom edge: no overlap.
		send_pair(make_pair(0, 0, 0, 0, 1024, 1024, 1024, 0, 1024, 1024));
		send_pair(make_pair(0, 0, 0, 0, 1024, 1024, 0, 1024, 1024, 1024));
		// Far apart.
		send_pair(make_pair(0, 0, 0, 0, 1024, 1024, 5000, -5000, 256, 256));
		// Zero width on the first, zero height on the second.
		send_pair(make_pair(0, 0, 100, 100, 0, 1024, 0, 0, 1024, 1024));
		send_pair(make_pair(0, 0, 0, 0, 1024, 1024, 100, 100, 1024, 0));
		// Extremes of corners and sizes.
		send_pair(make_pair(0, 0, CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, SMAX, SMAX));
		send_pair(make_pair(0, 0, CMIN, CMIN, SMAX, SMAX, CMIN, CMIN, 1, 1));
		send_pair(make_pair(0, 0, CMAX, CMAX, SMAX, SMAX, CMAX, CMAX, SMAX, SMAX));
		send_pair(make_pair(0, 0, -1, -1, 1, 1, -1, -1, 1, 1));
	endtask

	task automatic test_circle_pairs();
		// Centers close together.
		send_pair(make_pair(1, 1, 0, 0, 1024, 1024, 512, 0, 1024, 1024));
		// Boxes overlap at the corner, circles do not.
		send_pair(make_pair(1, 1, 0, 0, 1024, 1024, 900, 900, 1024, 1024));
		// Zero width circle never collides.
		send_pair(make_pair(1, 1, 0, 0, 0, 1024, 0, 0, 1024, 1024));
		// Tall circle box: height moves the center, width sets the radius.
		send_pair(make_pair(1, 1, 0, 0, 512, 2048, 0, 1500, 512, 512));
		// Extremes.
		send_pair(make_pair(1, 1, CMIN, CMIN, SMAX, SMAX, CMIN, CMIN, SMAX, SMAX));
		send_pair(make_pair(1, 1, CMAX, CMIN, SMAX, SMAX, CMAX, CMIN, 1, SMAX));
	endtask

	task automatic test_mixed_pairs();
		// Circle near the box corner: miss, then hit; both orders.
		send_pair(make_pair(0, 1, 0, 0, 1024, 1024, 960, 960, 512, 512));
		send_pair(make_pair(0, 1, 0, 0, 1024, 1024, 900, 900, 512, 512));
		send_pair(make_pair(1, 0, 960, 960, 512, 512, 0, 0, 1024, 1024));
		send_pair(make_pair(1, 0, 900, 900, 512, 512, 0, 0, 1024, 1024));
		// Circle center inside the box.
		send_pair(make_pair(1, 0, 100, 100, 256, 256, 0, 0, 4096, 4096));
		// Tall circle box against a box.
		send_pair(make_pair(0, 1, 0, 0, 4096, 256, 1000, -1900, 512, 4096));
		// Extremes.
		send_pair(make_pair(1, 0, CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, SMAX, SMAX));
		send_pair(make_pair(0, 1, CMIN, CMIN, SMAX, SMAX, -1, -1, SMAX, SMAX));
	endtask

	// Hold the response side off while requests keep coming, so the pipeline
	// fills and ready drops on the request side.
	task automatic test_response_stall();
		hold_off_left = 60;
		repeat (30)
			send_pair(random_near_pair());
	endtask

	// Pause requests until every response is back.
	task automatic test_drain_pause();
		repeat (20)
			send_pair(random_near_pair());
		wait_drained();
	endtask

	// Mostly pairs placed close together, the rest fully random.
	task automatic test_random_pairs(int count);
		repeat (count) begin
			if ($urandom_range(0, 9) < 8)
				send_pair(random_near_pair());
			else
				send_pair(random_any_pair());
		end
	endtask

	// Final stretch at full rate with no idling on either side.
	task automatic test_full_rate();
		wait_drained();
		idling_enabled = 1'b0;
		repeat (100)
			send_pair(random_near_pair());
	endtask

	// ------------------------------------------------------------------------
	// Clock, timeout, response side and checking
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever
			#4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Response ready: a long hold-off when asked, else random stall bursts.
	initial begin : drive_response_ready
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted response with the oldest predicted verdict.
	always @(posedge clk) begin : check_responses
		verdict_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: response with no request outstanding: collides=%0b boxes_overlap=%0b",
				         $time, result_ch.collides, result_ch.boxes_overlap);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (result_ch.boxes_overlap !== want.boxes_overlap) begin
					$display("%0t: boxes_overlap mismatch: expected %0b, actual %0b",
					         $time, want.boxes_overlap, result_ch.boxes_overlap);
					error_count++;
				end
				if (result_ch.collides !== want.collides) begin
					$display("%0t: collides mismatch: expected %0b, actual %0b",
					         $time, want.collides, result_ch.collides);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		error_count    = 0;
		hold_off_left  = 0;
		idling_enabled = 1'b1;
		arst_n        <= 1'b0;
		pair_ch.valid <= 1'b0;
		load_payload(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_box_pairs();
		test_circle_pairs();
		test_mixed_pairs();
		test_response_stall();
		test_drain_pause();
		test_random_pairs(1500);
		test_full_rate();

		// Let the last responses come back, then allow the pipeline to settle.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
